>>> rtl/sfr_pkg.sv
// Shared types and constants for the stream find-and-replace block.
`timescale 1ns / 1ps

package sfr_pkg;

    localparam int BYTE_W    = 8;
    localparam int CFG_W     = 64;
    localparam int LEN_W     = 4;
    localparam int CNT_W     = 4;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TARGET_BYTES = 2'd0,
        REG_TARGET_LEN   = 2'd1,
        REG_REPL_BYTES   = 2'd2,
        REG_REPL_LEN     = 2'd3
    } cfg_reg_t;

    // Control handed from the window to the output queue with each input word.
    typedef struct packed {
        logic [CNT_W-1:0] count;   // result words produced (0 when marker)
        logic             last;    // input word closed the string
        logic             marker;  // empty end marker instead of data
    } load_t;

endpackage

>>> rtl/sfr_cell.sv
// One window cell: holds a byte, takes the new byte or its neighbor's, compares.
`timescale 1ns / 1ps

module sfr_cell (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     wr,
    input  logic                     shift,
    input  logic [sfr_pkg::BYTE_W-1:0] in_byte,
    input  logic [sfr_pkg::BYTE_W-1:0] nb_byte,
    input  logic [sfr_pkg::BYTE_W-1:0] tgt_byte,
    output logic [sfr_pkg::BYTE_W-1:0] cur_byte,
    output logic                     eq
);
    import sfr_pkg::*;

    logic [BYTE_W-1:0] data_reg;
    logic [BYTE_W-1:0] data_next;

    // view of the cell after the incoming byte is written
    assign cur_byte = wr ? in_byte : data_reg;
    assign eq       = (cur_byte == tgt_byte);

    always_comb
    begin
        data_next = data_reg;
        if (en)
        begin
            data_next = shift ? nb_byte : cur_byte;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule

>>> rtl/sfr_window.sv
// Match window: chain of byte cells, fill counter and per-word result forming.
`timescale 1ns / 1ps

module sfr_window #(
    parameter int TARGET_MAX = 8,
    parameter int REPL_MAX   = 8,
    parameter int OUT_MAX    = 8
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  accept,
    input  logic [sfr_pkg::BYTE_W-1:0]            in_byte,
    input  logic                                  in_last,
    input  logic                                  clear_fill,
    input  logic [sfr_pkg::CFG_W-1:0]             target_bytes,
    input  logic [sfr_pkg::LEN_W-1:0]             target_length,
    input  logic [sfr_pkg::CFG_W-1:0]             replacement_bytes,
    input  logic [sfr_pkg::LEN_W-1:0]             replacement_length,
    output sfr_pkg::load_t                        load,
    output logic [OUT_MAX-1:0][sfr_pkg::BYTE_W-1:0] load_bytes
);
    import sfr_pkg::*;

    localparam int FILL_W = $clog2(TARGET_MAX + 1);

    logic [LEN_W-1:0]  len_c;
    logic [LEN_W-1:0]  rlen;
    logic [FILL_W-1:0] len;
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    logic [FILL_W-1:0] fill_w;
    logic [FILL_W-1:0] fill1;
    logic              full;
    logic              match;
    logic              shift;
    logic [CNT_W-1:0]  count;

    logic [TARGET_MAX-1:0][BYTE_W-1:0] cur;
    logic [TARGET_MAX-1:0]             eq;
    logic [TARGET_MAX-1:0]             wr;

    // clamp the lengths to what the hardware holds
    always_comb
    begin
        if (target_length == '0)
            len_c = LEN_W'(1);
        else if (target_length > LEN_W'(TARGET_MAX))
            len_c = LEN_W'(TARGET_MAX);
        else
            len_c = target_length;
        if (replacement_length > LEN_W'(REPL_MAX))
            rlen = LEN_W'(REPL_MAX);
        else
            rlen = replacement_length;
    end

    assign len    = FILL_W'(len_c);
    assign fill_w = (fill_reg >= len) ? '0 : fill_reg;
    assign fill1  = fill_w + FILL_W'(1);
    assign full   = (fill1 == len);

    genvar g;
    generate
        for (g = 0; g < TARGET_MAX; g++)
        begin : g_cell
            logic [BYTE_W-1:0] nb;
            if (g == TARGET_MAX - 1)
            begin : g_end
                assign nb = cur[g];
            end
            else
            begin : g_mid
                assign nb = cur[g+1];
            end
            assign wr[g] = (fill_w == FILL_W'(g));
            sfr_cell u_cell (
                .clk      (clk),
                .en       (accept),
                .wr       (wr[g]),
                .shift    (shift),
                .in_byte  (in_byte),
                .nb_byte  (nb),
                .tgt_byte (target_bytes[g*BYTE_W +: BYTE_W]),
                .cur_byte (cur[g]),
                .eq       (eq[g])
            );
        end
    endgenerate

    always_comb
    begin
        match = full;
        for (int i = 0; i < TARGET_MAX; i++)
        begin
            if (FILL_W'(i) < len && !eq[i])
                match = 1'b0;
        end
    end

    assign shift = full && !match && !in_last;

    always_comb
    begin
        if (match)
            count = CNT_W'(rlen);
        else if (in_last)
            count = CNT_W'(fill1);
        else
            count = full ? CNT_W'(1) : '0;
    end

    // bytes handed on: replacement on a match, otherwise the window oldest first
    always_comb
    begin
        for (int i = 0; i < OUT_MAX; i++)
        begin
            load_bytes[i] = '0;
            if (match)
            begin
                if (i < REPL_MAX)
                    load_bytes[i] = replacement_bytes[i*BYTE_W +: BYTE_W];
            end
            else if (i < TARGET_MAX)
            begin
                load_bytes[i] = cur[i];
            end
        end
    end

    assign load.count  = count;
    assign load.last   = in_last;
    assign load.marker = in_last && (count == '0);

    always_comb
    begin
        fill_next = fill_reg;
        if (clear_fill)
            fill_next = '0;
        else if (accept)
        begin
            if (match || in_last)
                fill_next = '0;
            else if (full)
                fill_next = len - FILL_W'(1);
            else
                fill_next = fill1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fill_reg <= '0;
        else
            fill_reg <= fill_next;
    end

endmodule

>>> rtl/sfr_outq.sv
// Output queue: shift chain of result bytes drained one word per handshake.
`timescale 1ns / 1ps

module sfr_outq #(
    parameter int OUT_MAX = 8
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  load_en,
    input  sfr_pkg::load_t                        load,
    input  logic [OUT_MAX-1:0][sfr_pkg::BYTE_W-1:0] load_bytes,
    output logic                                  can_load,
    output logic                                  res_valid,
    input  logic                                  res_ready,
    output logic [sfr_pkg::BYTE_W-1:0]            out_byte,
    output logic                                  out_valid,
    output logic                                  run_last,
    output logic                                  string_end
);
    import sfr_pkg::*;

    logic [OUT_MAX-1:0][BYTE_W-1:0] byte_reg;
    logic [OUT_MAX-1:0][BYTE_W-1:0] byte_next;
    logic [CNT_W-1:0]               cnt_reg;
    logic [CNT_W-1:0]               cnt_next;
    logic                           end_reg;
    logic                           end_next;
    logic                           mk_reg;
    logic                           mk_next;
    logic                           pop;

    assign res_valid = (cnt_reg != '0);
    assign pop       = res_valid && res_ready;
    assign can_load  = (cnt_reg == '0) || ((cnt_reg == CNT_W'(1)) && res_ready);

    assign out_byte   = mk_reg ? '0 : byte_reg[0];
    assign out_valid  = !mk_reg;
    assign run_last   = (cnt_reg == CNT_W'(1));
    assign string_end = run_last && end_reg;

    always_comb
    begin
        byte_next = byte_reg;
        cnt_next  = cnt_reg;
        end_next  = end_reg;
        mk_next   = mk_reg;
        if (load_en)
        begin
            byte_next = load_bytes;
            cnt_next  = load.marker ? CNT_W'(1) : load.count;
            end_next  = load.last;
            mk_next   = load.marker;
        end
        else if (pop)
        begin
            for (int i = 0; i < OUT_MAX - 1; i++)
                byte_next[i] = byte_reg[i+1];
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            end_reg <= 1'b0;
            mk_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            end_reg <= end_next;
            mk_reg  <= mk_next;
        end
    end

endmodule

>>> rtl/stream_find_replace_all.sv
// Top level of the streaming find-and-replace-all block.
// ---------------------------------------------------------------------------
// Usage:
//   Input words (in_byte, in_last) arrive on in_valid/in_ready. Every
//   leftmost, non-overlapping occurrence of the target is replaced by the
//   replacement; in_last flushes whatever the window still holds.
//   Result words (out_byte, out_valid, run_last, string_end) leave on
//   res_valid/res_ready. run_last marks the final word caused by one input
//   word, string_end the final word of the string. An input word that closes
//   the string with nothing to send yields one marker word with out_valid 0.
//   Registers are written on cfg_valid/cfg_ready (always ready) by index:
//   0 target bytes, 1 target length, 2 replacement bytes, 3 replacement length.
//   Writing the target length drops any held bytes. Write only while idle.
// Timing:
//   Results of a word show up in the cycle after accept.
//   With res_ready high, a word producing at most one result word is taken
//   every cycle. A word producing more result words holds off the next
//   accept until the output queue, draining one word per cycle, is down to
//   its last word.
// Reset / stall:
//   Reset empties window and output queue and loads register defaults.
//   When res_ready is low the queue holds and in_ready falls once the queue
//   cannot take the next word's results; nothing is dropped.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module stream_find_replace_all #(
    parameter int TARGET_MAX = 8,
    parameter int REPL_MAX   = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration writes
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [sfr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sfr_pkg::CFG_W-1:0]     cfg_data,
    // input stream
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [sfr_pkg::BYTE_W-1:0]    in_byte,
    input  logic                          in_last,
    // result stream
    output logic                          res_valid,
    input  logic                          res_ready,
    output logic [sfr_pkg::BYTE_W-1:0]    out_byte,
    output logic                          out_valid,
    output logic                          run_last,
    output logic                          string_end
);
    import sfr_pkg::*;

    localparam int OUT_MAX = (TARGET_MAX > REPL_MAX) ? TARGET_MAX : REPL_MAX;

    logic [CFG_W-1:0] tgt_bytes_reg;
    logic [CFG_W-1:0] tgt_bytes_next;
    logic [LEN_W-1:0] tgt_len_reg;
    logic [LEN_W-1:0] tgt_len_next;
    logic [CFG_W-1:0] rep_bytes_reg;
    logic [CFG_W-1:0] rep_bytes_next;
    logic [LEN_W-1:0] rep_len_reg;
    logic [LEN_W-1:0] rep_len_next;
    logic             cfg_wr;
    logic             clear_fill;

    logic             accept;
    logic             can_load;
    load_t            load;
    logic [OUT_MAX-1:0][BYTE_W-1:0] load_bytes;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    // register file; a target length write also restarts the window
    always_comb
    begin
        tgt_bytes_next = tgt_bytes_reg;
        tgt_len_next   = tgt_len_reg;
        rep_bytes_next = rep_bytes_reg;
        rep_len_next   = rep_len_reg;
        clear_fill     = 1'b0;
        if (cfg_wr)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_TARGET_BYTES: tgt_bytes_next = cfg_data;
                REG_TARGET_LEN:
                begin
                    tgt_len_next = cfg_data[LEN_W-1:0];
                    clear_fill   = 1'b1;
                end
                REG_REPL_BYTES:   rep_bytes_next = cfg_data;
                REG_REPL_LEN:     rep_len_next   = cfg_data[LEN_W-1:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tgt_bytes_reg <= '0;
            tgt_len_reg   <= LEN_W'(1);
            rep_bytes_reg <= '0;
            rep_len_reg   <= '0;
        end
        else
        begin
            tgt_bytes_reg <= tgt_bytes_next;
            tgt_len_reg   <= tgt_len_next;
            rep_bytes_reg <= rep_bytes_next;
            rep_len_reg   <= rep_len_next;
        end
    end

    // take a word whenever the queue can absorb all its results
    assign in_ready = can_load;
    assign accept   = in_valid && in_ready;

    sfr_window #(
        .TARGET_MAX (TARGET_MAX),
        .REPL_MAX   (REPL_MAX),
        .OUT_MAX    (OUT_MAX)
    ) u_window (
        .clk                (clk),
        .rst_n              (rst_n),
        .accept             (accept),
        .in_byte            (in_byte),
        .in_last            (in_last),
        .clear_fill         (clear_fill),
        .target_bytes       (tgt_bytes_reg),
        .target_length      (tgt_len_reg),
        .replacement_bytes  (rep_bytes_reg),
        .replacement_length (rep_len_reg),
        .load               (load),
        .load_bytes         (load_bytes)
    );

    sfr_outq #(
        .OUT_MAX (OUT_MAX)
    ) u_outq (
        .clk        (clk),
        .rst_n      (rst_n),
        .load_en    (accept && ((load.count != '0) || load.marker)),
        .load       (load),
        .load_bytes (load_bytes),
        .can_load   (can_load),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .out_byte   (out_byte),
        .out_valid  (out_valid),
        .run_last   (run_last),
        .string_end (string_end)
    );

endmodule

>>> sim/stream_find_replace_all_test.sv
// Self-checking testbench for the stream find-and-replace-all block.
`timescale 1ns / 1ps

module stream_find_replace_all_test;

    import sfr_pkg::*;

    localparam int TARGET_MAX  = 8;
    localparam int REPL_MAX    = 8;
    localparam int RAND_WORDS  = 195;   // random source words to send
    localparam int SETTLE      = 4;     // idle cycles after the last result
    localparam int STALL_LIMIT = 2000;  // cycles with no handshake at all

    // one source word as queued for the driver
    typedef struct packed {
        logic [7:0] data;
        logic       fin;
    } src_word_t;

    // one result word as the block should emit it
    typedef struct packed {
        logic [7:0] data;
        logic       valid;
        logic       run_end;
        logic       str_end;
    } res_word_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    cfg_reg_t   cfg_index = REG_TARGET_BYTES;
    logic [63:0] cfg_data = '0;

    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [7:0] in_byte = '0;
    logic       in_last = 1'b0;

    logic       res_valid;
    logic       res_ready = 1'b0;
    logic [7:0] out_byte;
    logic       out_valid;
    logic       run_last;
    logic       string_end;

    stream_find_replace_all #(
        .TARGET_MAX (TARGET_MAX),
        .REPL_MAX   (REPL_MAX)
    ) uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_byte    (in_byte),
        .in_last    (in_last),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .out_byte   (out_byte),
        .out_valid  (out_valid),
        .run_last   (run_last),
        .string_end (string_end)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Shadow of the block: register copies plus the match window.
    // ------------------------------------------------------------------
    logic [63:0] tgt_bytes_reg = '0;
    logic [3:0]  tgt_len_reg   = 4'd1;
    logic [63:0] rep_bytes_reg = '0;
    logic [3:0]  rep_len_reg   = 4'd0;
    logic [7:0]  held_bytes [8];
    int          held = 0;

    src_word_t   source_q [$];     // words waiting for the driver
    res_word_t   rewritten_q [$];  // expected rewritten words, oldest first

    int words_queued   = 0;
    int words_in       = 0;
    int words_out      = 0;
    int replacements   = 0;
    int strings_closed = 0;
    int reg_writes     = 0;
    int mismatches     = 0;

    // target length as the block uses it: 0 acts as 1, anything past 8 as 8
    function automatic int eff_target_len();
        if (tgt_len_reg == 0)
            return 1;
        if (tgt_len_reg > TARGET_MAX)
            return TARGET_MAX;
        return tgt_len_reg;
    endfunction

    // Push one accepted source word through the window and queue the words
    // it rewrites to.
    function automatic void rewrite_word(input logic [7:0] b, input logic fin);
        int        tl;
        int        rl;
        int        i;
        int        n;
        bit        hit;
        res_word_t outs [9];
        tl = eff_target_len();
        rl = (rep_len_reg > REPL_MAX) ? REPL_MAX : rep_len_reg;
        n  = 0;
        if (held >= tl)
            held = 0;
        held_bytes[held] = b;
        held++;
        if (held == tl)
        begin
            hit = 1'b1;
            for (i = 0; i < tl; i++)
                if (held_bytes[i] != tgt_bytes_reg[8*i +: 8])
                    hit = 1'b0;
            if (hit)
            begin
                for (i = 0; i < rl; i++)
                begin
                    outs[n] = '{rep_bytes_reg[8*i +: 8], 1'b1, 1'b0, 1'b0};
                    n++;
                end
                held = 0;
                replacements++;
            end
            else
            begin
                // no match: oldest byte leaves, window slides by one
                outs[n] = '{held_bytes[0], 1'b1, 1'b0, 1'b0};
                n++;
                for (i = 0; i + 1 < tl; i++)
                    held_bytes[i] = held_bytes[i + 1];
                held = tl - 1;
            end
        end
        if (fin)
        begin
            // end of string flushes whatever could still have matched
            for (i = 0; i < held; i++)
            begin
                outs[n] = '{held_bytes[i], 1'b1, 1'b0, 1'b0};
                n++;
            end
            held = 0;
            if (n == 0)
            begin
                outs[0] = '{8'h00, 1'b0, 1'b0, 1'b0};  // empty end marker
                n = 1;
            end
            outs[n - 1].str_end = 1'b1;
            strings_closed++;
        end
        if (n > 0)
            outs[n - 1].run_end = 1'b1;
        for (i = 0; i < n; i++)
            rewritten_q.push_back(outs[i]);
    endfunction

    // random wait between words, with spells of back-to-back traffic in between
    function automatic int draw_pause(inout bit calm);
        if ($urandom_range(0, 19) == 0)
            calm = !calm;
        return calm ? 0 : $urandom_range(0, 6);
    endfunction

    // ------------------------------------------------------------------
    // Source driver: one word from source_q at a time, held until taken.
    // ------------------------------------------------------------------
    int        src_gap = 0;
    bit        src_calm = 1'b0;
    src_word_t launch_w;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            src_gap  <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                rewrite_word(in_byte, in_last);
                words_in++;
            end
            // only move on once the current word is gone
            if (!in_valid || in_ready)
            begin
                if (src_gap != 0)
                begin
                    in_valid <= 1'b0;
                    src_gap  <= src_gap - 1;
                end
                else if (source_q.size() != 0)
                begin
                    launch_w = source_q.pop_front();
                    in_valid <= 1'b1;
                    in_byte  <= launch_w.data;
                    in_last  <= launch_w.fin;
                    src_gap  <= draw_pause(src_calm);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: random back-pressure, compare against rewritten_q.
    // ------------------------------------------------------------------
    int        sink_hold = 0;
    int        next_hold;
    bit        sink_calm = 1'b0;
    res_word_t got_w;
    res_word_t want_w;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            res_ready <= 1'b0;
            sink_hold <= 0;
        end
        else if (res_valid && res_ready)
        begin
            got_w = '{out_byte, out_valid, run_last, string_end};
            words_out++;
            if (rewritten_q.size() == 0)
            begin
                $display("%0t: unexpected word byte=%h valid=%b run_last=%b end=%b",
                         $time, got_w.data, got_w.valid, got_w.run_end,
                         got_w.str_end);
                mismatches++;
            end
            else
            begin
                want_w = rewritten_q.pop_front();
                if (got_w !== want_w)
                begin
                    $display("%0t: mismatch exp %h %b %b %b, got %h %b %b %b",
                             $time, want_w.data, want_w.valid, want_w.run_end,
                             want_w.str_end, got_w.data, got_w.valid,
                             got_w.run_end, got_w.str_end);
                    mismatches++;
                end
            end
            next_hold = draw_pause(sink_calm);
            sink_hold <= next_hold;
            res_ready <= (next_hold == 0);
        end
        else if (sink_hold != 0)
        begin
            sink_hold <= sink_hold - 1;
            res_ready <= (sink_hold == 1);
        end
        else
            res_ready <= 1'b1;
    end

    // ------------------------------------------------------------------
    // Watchdog: any handshake counts as progress.
    // ------------------------------------------------------------------
    int quiet_cycles = 0;

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (res_valid && res_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles == STALL_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
            $display("CHECK FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic queue_word(input logic [7:0] b, input logic fin);
        source_q.push_back('{b, fin});
        words_queued++;
    endtask

    // wait until every queued word is taken and every result has come back,
    // then wait out the SETTLE idle time for words that made no result
    task automatic drain();
        while (words_in != words_queued || rewritten_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // register write; only called while the block is idle
    task automatic write_reg(input cfg_reg_t idx, input logic [63:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
        case (idx)
            REG_TARGET_BYTES: tgt_bytes_reg = val;
            REG_TARGET_LEN:
            begin
                tgt_len_reg = val[3:0];
                held = 0;  // held bytes are dropped
            end
            REG_REPL_BYTES:   rep_bytes_reg = val;
            REG_REPL_LEN:     rep_len_reg = val[3:0];
            default: ;
        endcase
        reg_writes++;
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    logic [7:0] alpha [3];
    logic [7:0] str_q [$];

    initial
    begin
        int          rand_words;
        int          phases;
        int          n_str;
        int          s;
        int          j;
        int          m;
        int          slen;
        bit          open_end;
        logic [63:0] val;
        rand_words = 0;
        phases     = 0;
        for (j = 0; j < 3; j++)
            alpha[j] = 8'($urandom);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: 1-byte target 00, delete. Last word deleted too,
        // so the string closes with an empty end marker.
        queue_word(8'h00, 1'b0);
        queue_word(8'h41, 1'b0);
        queue_word(8'h00, 1'b1);
        drain();

        // "abc" -> "XYZW": miss, hit, then a partial match flushed at the end
        write_reg(REG_TARGET_BYTES, 64'h0000_0000_0063_6261);
        write_reg(REG_TARGET_LEN, 64'd3);
        write_reg(REG_REPL_BYTES, 64'h0000_0000_575A_5958);
        write_reg(REG_REPL_LEN, 64'd4);
        queue_word(8'h7A, 1'b0);
        queue_word(8'h61, 1'b0);
        queue_word(8'h62, 1'b0);
        queue_word(8'h63, 1'b0);
        queue_word(8'h61, 1'b0);
        queue_word(8'h62, 1'b1);
        // string shorter than the target passes through
        queue_word(8'h61, 1'b0);
        queue_word(8'h62, 1'b1);
        drain();

        // target length 0 acts as 1, replacement length 15 acts as 8
        write_reg(REG_TARGET_BYTES, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(REG_TARGET_LEN, 64'd0);
        write_reg(REG_REPL_BYTES, 64'h0);
        write_reg(REG_REPL_LEN, 64'd15);
        queue_word(8'hFF, 1'b0);
        queue_word(8'h00, 1'b0);
        queue_word(8'hFF, 1'b1);
        drain();

        // length 15 acts as 8; full-length match on the last word, deleted
        write_reg(REG_TARGET_BYTES, 64'h0123_4567_89AB_CDEF);
        write_reg(REG_TARGET_LEN, 64'd15);
        write_reg(REG_REPL_LEN, 64'd0);
        for (j = 0; j < 8; j++)
            queue_word(tgt_bytes_reg[8*j +: 8], j == 7);
        drain();

        // Random phases. Strings are built mostly from target copies and
        // bytes of a small alphabet so matches are frequent; some copies are
        // cut short. A phase may end mid-string, so the next register writes
        // land while the window still holds bytes.
        while (rand_words < RAND_WORDS)
        begin
            if (phases == 0 || $urandom_range(0, 1))
            begin
                if ($urandom_range(0, 2) == 0)
                    for (j = 0; j < 3; j++)
                        alpha[j] = 8'($urandom);
                for (j = 0; j < 8; j++)
                    val[8*j +: 8] = ($urandom_range(0, 5) == 0) ? 8'($urandom)
                                                                : alpha[$urandom_range(0, 2)];
                write_reg(REG_TARGET_BYTES, val);
            end
            if (phases == 0 || $urandom_range(0, 1))
            begin
                val = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom} : 64'h0;
                val[3:0] = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15))
                                                       : 4'($urandom_range(1, 4));
                write_reg(REG_TARGET_LEN, val);
            end
            if (phases == 0 || $urandom_range(0, 1))
                write_reg(REG_REPL_BYTES, {$urandom, $urandom});
            if (phases == 0 || $urandom_range(0, 1))
            begin
                val = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom} : 64'h0;
                val[3:0] = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15))
                                                       : 4'($urandom_range(0, 3));
                write_reg(REG_REPL_LEN, val);
            end

            n_str = $urandom_range(1, 3);
            for (s = 0; s < n_str; s++)
            begin
                slen     = $urandom_range(1, 12);
                open_end = (s == n_str - 1) && ($urandom_range(0, 3) == 0);
                str_q.delete();
                while (str_q.size() < slen)
                begin
                    if ($urandom_range(0, 1))
                    begin
                        // target copy, now and then broken off early
                        m = ($urandom_range(0, 3) == 0) ? $urandom_range(1, eff_target_len())
                                                        : eff_target_len();
                        for (j = 0; j < m; j++)
                            str_q.push_back(tgt_bytes_reg[8*j +: 8]);
                    end
                    else if ($urandom_range(0, 3) == 0)
                        str_q.push_back(8'($urandom));
                    else
                        str_q.push_back(alpha[$urandom_range(0, 2)]);
                end
                for (j = 0; j < str_q.size(); j++)
                    queue_word(str_q[j], !open_end && j == str_q.size() - 1);
                rand_words += str_q.size();
            end
            drain();
            phases++;
        end

        drain();
        $display("Sent %0d source words, checked %0d result words, %0d replacements.",
                 words_in, words_out, replacements);
        $display("Closed %0d strings over %0d random settings, %0d register writes.",
                 strings_closed, phases, reg_writes);
        if (mismatches == 0 && rewritten_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
